// ===== rtl/core/pycrp_pkg.sv =====
package pycrp_pkg;

  // request item: one action on the restaurant
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  table_id;
    logic [15:0] random_fraction;
  } req_item_t;

  // response item: one per request
  typedef struct packed {
    logic [8:0] chosen_table;
    logic       new_table;
    logic [1:0] status;
  } rsp_item_t;

  // action codes
  localparam logic [1:0] ACT_SAMPLE      = 2'd0;
  localparam logic [1:0] ACT_INCORPORATE = 2'd1;
  localparam logic [1:0] ACT_REMOVE      = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_CONCENTRATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 2'd1;

  // field limits
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;
  localparam logic [8:0]  NEXT_MAX  = 9'd511;
  localparam logic [23:0] CONCENTRATION_RESET = 24'd4096;

endpackage

// ===== rtl/core/pitman_yor_crp_table_sampler.sv =====
// channel  signals                       direction  item accepted when
// req      req_valid, req_stall, req     in         req_valid && !req_stall
// rsp      rsp_valid, rsp_stall, rsp     out        rsp_valid && !rsp_stall
// cfg      cfg_valid, cfg_ready,         in         cfg_valid && cfg_ready
//          cfg_index, cfg_data
//
// sample reads the count memory slots in turn through its single read port until a hit
//   or the last slot, in steps: accept, scaling multiply, slot walk, result load
// incorporate, remove: accept, read, modify/write, result load; a bad id skips to load
// after rst a clearing pass zeroes every count memory entry, req stalled
// one item in flight; the result sits in the rsp register so the next item can be taken
// while it waits, a stalled rsp holds the following result in the result stage
module pitman_yor_crp_table_sampler
  import pycrp_pkg::*;
#(
  parameter int MAX_TABLE_IDS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_item_t             req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_item_t             rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ID_W  = (MAX_TABLE_IDS > 1) ? $clog2(MAX_TABLE_IDS) : 1;
  localparam int CNT_W = ID_W + 1;
  // each table weight is below 2^28, the sum of all of them fits here
  localparam int SUM_W = 28 + ID_W;
  localparam int TGT_W = 37;
  localparam int CMP_W = (SUM_W > TGT_W) ? SUM_W : TGT_W;
  localparam logic [16:0]     MAX_L    = 17'(MAX_TABLE_IDS);
  localparam logic [ID_W-1:0] LAST_ID  = ID_W'(MAX_TABLE_IDS - 1);
  localparam logic [CNT_W-1:0] WALK_END = CNT_W'(MAX_TABLE_IDS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCALE,
    S_WALK,
    S_LOOKUP,
    S_MODIFY,
    S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [23:0] concentration;
  logic [11:0] discount;

  // scalar state
  logic [8:0]  open_tables;
  logic [23:0] total_customers;
  logic [8:0]  next_table;

  // item and result holding
  req_item_t item;
  rsp_item_t res;

  // clearing pass and walk bookkeeping
  logic [ID_W-1:0]  clr_addr;
  logic [CNT_W-1:0] walk_addr;
  logic             rd_pend;
  logic [ID_W-1:0]  rd_idx;
  logic [TGT_W-1:0] target_hi;
  logic [SUM_W-1:0] sum;

  // count memory, one read and one write port
  logic [15:0] seat_counts [MAX_TABLE_IDS];
  logic [15:0] rd_data;
  logic [ID_W-1:0] rd_addr;
  logic [ID_W-1:0] wr_addr;
  logic [15:0]     wr_data;
  logic            mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seat_counts[wr_addr] <= wr_data;
    end
    rd_data <= seat_counts[rd_addr];
  end

  // request side
  logic            req_id_ok;
  logic [ID_W-1:0] item_addr;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign req_id_ok = (17'(req.table_id) < MAX_L);
  assign item_addr = ID_W'(item.table_id);

  // scaled draw: u * (customers * 2^12 + alpha); only the bits above 2^16 matter
  // since u*W < sum*2^16 holds exactly when floor(u*W / 2^16) < sum
  logic [36:0] weight_total;
  logic [52:0] product;

  assign weight_total = 37'({total_customers, 12'b0}) + 37'(concentration);
  assign product      = 53'(item.random_fraction) * 53'(weight_total);

  // walk step on the count read back from the memory
  logic [27:0]      table_weight;
  logic [SUM_W-1:0] sum_next;
  logic             occupied;
  logic             hit;

  assign occupied     = (rd_data != 16'd0);
  assign table_weight = {rd_data, 12'b0} - 28'(discount);
  assign sum_next     = sum + SUM_W'(table_weight);
  assign hit          = occupied && (CMP_W'(target_hi) < CMP_W'(sum_next));

  // seat / unseat on the count read back from the memory
  logic        mod_write;
  logic [15:0] mod_count;
  logic [1:0]  mod_status;

  always_comb begin
    mod_write  = 1'b0;
    mod_count  = rd_data;
    mod_status = ST_OK;
    case (item.action)
      ACT_INCORPORATE: begin
        if (rd_data == COUNT_MAX || total_customers == TOTAL_MAX) begin
          mod_status = ST_SATURATED;
        end else begin
          mod_write = 1'b1;
          mod_count = rd_data + 16'd1;
        end
      end
      ACT_REMOVE: begin
        if (!occupied) begin
          mod_status = ST_EMPTY;
        end else begin
          mod_write = 1'b1;
          mod_count = rd_data - 16'd1;
        end
      end
      default: begin
        mod_write = 1'b0;
      end
    endcase
  end

  // memory port steering
  always_comb begin
    rd_addr = (state == S_WALK) ? walk_addr[ID_W-1:0] : item_addr;
    wr_addr = item_addr;
    wr_data = mod_count;
    mem_we  = 1'b0;
    case (state)
      S_CLEAR: begin
        wr_addr = clr_addr;
        wr_data = 16'd0;
        mem_we  = 1'b1;
      end
      S_MODIFY: begin
        mem_we = mod_write;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      concentration   <= CONCENTRATION_RESET;
      discount        <= 12'd0;
      open_tables     <= 9'd0;
      total_customers <= 24'd0;
      next_table      <= 9'd0;
      rsp_valid       <= 1'b0;
      rd_pend         <= 1'b0;
      walk_addr       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CONCENTRATION: concentration <= cfg_data;
          CFG_DISCOUNT:      discount      <= cfg_data[11:0];
          default: begin
          end
        endcase
      end

      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        // zero one count entry per cycle
        S_CLEAR: begin
          clr_addr <= clr_addr + ID_W'(1);
          if (clr_addr == LAST_ID) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req_valid) begin
            item <= req;
            res.chosen_table <= {1'b0, req.table_id};
            res.new_table    <= 1'b0;
            res.status       <= ST_OK;
            case (req.action)
              ACT_SAMPLE: state <= S_SCALE;
              ACT_INCORPORATE: begin
                if (req_id_ok) begin
                  state <= S_LOOKUP;
                end else begin
                  res.status <= ST_EXHAUSTED;
                  state      <= S_EMIT;
                end
              end
              ACT_REMOVE: begin
                if (req_id_ok) begin
                  state <= S_LOOKUP;
                end else begin
                  res.status <= ST_EMPTY;
                  state      <= S_EMIT;
                end
              end
              default: state <= S_EMIT;
            endcase
          end
        end

        // register the scaled draw, set up the walk
        S_SCALE: begin
          target_hi <= product[52:16];
          sum       <= '0;
          walk_addr <= '0;
          rd_pend   <= 1'b0;
          state     <= S_WALK;
        end

        // one slot read issued per cycle, the previous read evaluated
        S_WALK: begin
          rd_pend <= (walk_addr != WALK_END);
          rd_idx  <= walk_addr[ID_W-1:0];
          if (walk_addr != WALK_END) begin
            walk_addr <= walk_addr + CNT_W'(1);
          end
          if (rd_pend) begin
            if (occupied) begin
              sum <= sum_next;
            end
            if (hit) begin
              res.chosen_table <= 9'(rd_idx);
              res.new_table    <= 1'b0;
              res.status       <= ST_OK;
              rd_pend          <= 1'b0;
              state            <= S_EMIT;
            end else if (rd_idx == LAST_ID) begin
              // no occupied table taken: report the next unused id as a new table
              res.chosen_table <= next_table;
              res.new_table    <= 1'b1;
              res.status       <= (17'(next_table) >= MAX_L) ? ST_EXHAUSTED : ST_OK;
              rd_pend          <= 1'b0;
              state            <= S_EMIT;
            end
          end
        end

        // count read in flight
        S_LOOKUP: begin
          state <= S_MODIFY;
        end

        // write back the new count and update totals
        S_MODIFY: begin
          res.status <= mod_status;
          if (mod_write) begin
            if (item.action == ACT_INCORPORATE) begin
              total_customers <= total_customers + 24'd1;
              if (!occupied) begin
                open_tables <= open_tables + 9'd1;
                if (next_table < NEXT_MAX) begin
                  next_table <= next_table + 9'd1;
                end
              end
            end else begin
              if (total_customers != 24'd0) begin
                total_customers <= total_customers - 24'd1;
              end
              if (rd_data == 16'd1 && open_tables != 9'd0) begin
                open_tables <= open_tables - 9'd1;
              end
            end
          end
          state <= S_EMIT;
        end

        // hand the result to the rsp register once it is free
        S_EMIT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // a sample walk only reads the count memory
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> !mem_we)
    else $error("count memory written during sample walk");

  // a table opened below NEXT_MAX advances next_table, which never lags the open count
  assert property (@(posedge clk) disable iff (rst)
    (MAX_TABLE_IDS > 511) || (open_tables <= next_table))
    else $error("open table count ahead of next table id");

  // a new table result reports ok or ids exhausted only
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.new_table) |->
      (rsp.status == ST_OK || rsp.status == ST_EXHAUSTED))
    else $error("bad status on new table result");
`endif

endmodule
